[rtl/pata_pkg.sv]
// Package for the palette allocator / tiled address block.
// Holds sizes, address constants, status codes, FSM state and RAM request types.
// No dependencies.
package pata_pkg;

  localparam int FIRST_ENTRY  = 16;
  localparam int TABLE_DEPTH  = 256;
  localparam int TADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W        = 9;
  localparam int IDX_W        = 8;
  localparam int COLOUR_W     = 24;
  localparam int BADDR_W      = 15;
  localparam int X_W          = 9;
  localparam int Y_W          = 6;
  localparam int HEADER_BYTES = 'h300;
  localparam int LOGO_WIDTH   = 64;
  localparam int BANNER_WIDTH = 320;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                we;
    logic [TADDR_W-1:0]  waddr;
    logic [COLOUR_W-1:0] wdata;
    logic [TADDR_W-1:0]  raddr;
  } ram_req_t;

endpackage

[rtl/pata_colour_ram.sv]
// Palette colour store: one write port, one read port, registered read data.
// Depends on pata_pkg.
module pata_colour_ram
  import pata_pkg::*;
(
  input  logic                clk_i,
  input  ram_req_t            req_i,
  output logic [COLOUR_W-1:0] rdata_o
);

  logic [COLOUR_W-1:0] mem [TABLE_DEPTH];
  logic [COLOUR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pata_addr_calc.sv]
// Tiled byte address and image bound check for one pixel coordinate.
// Depends on pata_pkg.
module pata_addr_calc
  import pata_pkg::*;
(
  input  logic [X_W-1:0]     pixel_x_i,
  input  logic [Y_W-1:0]     pixel_y_i,
  input  logic               banner_i,
  output logic [BADDR_W-1:0] byte_address_o,
  output logic               outside_o
);

  logic [11:0]        in_tile;
  logic [2:0]         tile_row;
  logic [BADDR_W-1:0] row_term;

  // (x&7) + (y&7)*8 + (x>>3)*64 occupy disjoint bits
  assign in_tile  = {pixel_x_i[8:3], pixel_y_i[2:0], pixel_x_i[2:0]};
  assign tile_row = pixel_y_i[5:3];

  always_comb begin
    if (banner_i) begin
      row_term = BADDR_W'({tile_row, 11'd0}) + BADDR_W'({tile_row, 9'd0});
    end else begin
      row_term = BADDR_W'({tile_row, 9'd0});
    end
  end

  assign byte_address_o = BADDR_W'(HEADER_BYTES) + BADDR_W'(in_tile) + row_term;
  assign outside_o      = banner_i ? (pixel_x_i >= X_W'(BANNER_WIDTH))
                                   : (pixel_x_i >= X_W'(LOGO_WIDTH));

endmodule

[rtl/pata_search.sv]
// Sequencer: walks the allocated palette entries one per cycle through the
// shared comparator, allocates on a miss and holds the result register.
// Depends on pata_pkg; drives pata_colour_ram.
module pata_search
  import pata_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [COLOUR_W-1:0] rgb_i,
  input  logic [BADDR_W-1:0]  addr_i,
  input  logic                outside_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IDX_W-1:0]    colour_index_o,
  output logic [BADDR_W-1:0]  byte_address_o,
  output logic [1:0]          status_o,
  output ram_req_t            ram_req_o,
  input  logic [COLOUR_W-1:0] ram_rdata_i
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                cmp_v_q, cmp_v_d;
  logic [COLOUR_W-1:0] rgb_q, rgb_d;
  logic [BADDR_W-1:0]  addr_q, addr_d;
  logic [IDX_W-1:0]    res_idx_q, res_idx_d;
  status_e             res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    out_idx_q, out_idx_d;
  logic [BADDR_W-1:0]  out_addr_q, out_addr_d;
  status_e             out_status_q, out_status_d;

  logic issue, match, full, slot_free;

  assign issue     = ptr_q < fill_q;
  assign match     = cmp_v_q && (ram_rdata_i == rgb_q);
  assign full      = fill_q >= CNT_W'(TABLE_DEPTH);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = outside_i ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (match || !issue) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    fill_d        = fill_q;
    ptr_d         = ptr_q;
    cmp_idx_d     = cmp_idx_q;
    cmp_v_d       = 1'b0;
    rgb_d         = rgb_q;
    addr_d        = addr_q;
    res_idx_d     = res_idx_q;
    res_status_d  = res_status_q;
    out_idx_d     = out_idx_q;
    out_addr_d    = out_addr_q;
    out_status_d  = out_status_q;
    out_valid_d   = out_ready_i ? 1'b0 : out_valid_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = fill_q[TADDR_W-1:0];
    ram_req_o.wdata = rgb_q;
    ram_req_o.raddr = ptr_q[TADDR_W-1:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rgb_d  = rgb_i;
          addr_d = outside_i ? '0 : addr_i;
          ptr_d  = CNT_W'(FIRST_ENTRY);
          if (outside_i) begin
            res_idx_d    = '0;
            res_status_d = STATUS_OUTSIDE;
          end
        end
      end
      ST_SEARCH: begin
        cmp_v_d   = issue;
        cmp_idx_d = ptr_q;
        ptr_d     = ptr_q + CNT_W'(1);
        if (match) begin
          res_idx_d    = IDX_W'(cmp_idx_q);
          res_status_d = STATUS_OK;
        end else if (!issue) begin
          if (full) begin
            res_idx_d    = '0;
            res_status_d = STATUS_FULL;
          end else begin
            ram_req_o.we = 1'b1;
            res_idx_d    = IDX_W'(fill_q);
            res_status_d = STATUS_OK;
            fill_d       = fill_q + CNT_W'(1);
          end
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_idx_d    = res_idx_q;
          out_addr_d   = addr_q;
          out_status_d = res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= CNT_W'(FIRST_ENTRY);
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    cmp_idx_q    <= cmp_idx_d;
    rgb_q        <= rgb_d;
    addr_q       <= addr_d;
    res_idx_q    <= res_idx_d;
    res_status_q <= res_status_d;
    out_idx_q    <= out_idx_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign colour_index_o = out_idx_q;
  assign byte_address_o = out_addr_q;
  assign status_o       = out_status_q;

endmodule

[rtl/palette_alloc_tile_address.sv]
// Palette allocator with 8x8-tiled byte address generation (top level).
// Depends on pata_pkg, pata_addr_calc, pata_search, pata_colour_ram.
//
// Input channel (in_valid_i/in_ready_o) carries one pixel: coordinate and RGB.
// Output channel (out_valid_o/out_ready_i) carries the palette index, the
// byte address after the 0x300-byte header and a status code.
// cfg_we_i writes the layout bit banner_q (0: 64x64 logo, 1: 320x64 banner).
//
// One transaction at a time: the next pixel is taken only once the search for
// the last one is done. The search ends early on a hit: the single comparator
// checks one stored colour per cycle out of the colour RAM, whose read is
// registered. Without a hit it walks every allocated entry, then allocates a
// new one unless the palette is full; an outside coordinate skips the search.
// The next pixel is accepted while an earlier result still waits in the
// output register; a stalled receiver only holds the block once a second
// result is ready.
// Reset empties the palette (fill count back to the first usable entry),
// selects the logo layout and drops any pending result. No clearing pass.
module palette_alloc_tile_address
  import pata_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [X_W-1:0]     pixel_x_i,
  input  logic [Y_W-1:0]     pixel_y_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IDX_W-1:0]   colour_index_o,
  output logic [BADDR_W-1:0] byte_address_o,
  output logic [1:0]         status_o
);

  logic                banner_q;
  logic [BADDR_W-1:0]  pix_addr;
  logic                outside;
  ram_req_t            ram_req;
  logic [COLOUR_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banner_q <= 1'b0;
    end else if (cfg_we_i) begin
      banner_q <= cfg_wdata_i;
    end
  end

  pata_addr_calc u_addr_calc (
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .banner_i       (banner_q),
    .byte_address_o (pix_addr),
    .outside_o      (outside)
  );

  pata_search u_search (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rgb_i          ({red_i, green_i, blue_i}),
    .addr_i         (pix_addr),
    .outside_i      (outside),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .colour_index_o (colour_index_o),
    .byte_address_o (byte_address_o),
    .status_o       (status_o),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata)
  );

  pata_colour_ram u_colour_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule

[rtl/pata_checker.sv]
// Port-level checks for palette_alloc_tile_address, attached by bind.
// Depends on pata_pkg.
module pata_port_checks
  import pata_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [IDX_W-1:0]   colour_index_o,
  input logic [BADDR_W-1:0] byte_address_o,
  input logic [1:0]         status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(colour_index_o) && $stable(byte_address_o))
    else $error("output transaction dropped or changed while stalled");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OUTSIDE |-> colour_index_o == '0
      && byte_address_o == '0)
    else $error("outside pixel with nonzero index or address");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |-> colour_index_o == '0
      && byte_address_o >= BADDR_W'(HEADER_BYTES))
    else $error("full palette result malformed");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |->
      colour_index_o >= IDX_W'(FIRST_ENTRY) && byte_address_o >= BADDR_W'(HEADER_BYTES))
    else $error("ok result with reserved index or address in header");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == STATUS_OK || status_o == STATUS_FULL
      || status_o == STATUS_OUTSIDE)
    else $error("undefined status code");

endmodule

bind palette_alloc_tile_address pata_port_checks u_pata_port_checks (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .colour_index_o (colour_index_o),
  .byte_address_o (byte_address_o),
  .status_o       (status_o)
);
